// ===== rtl/core/bfx_pkg.sv =====
package bfx_pkg;

    localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;

    localparam int BIT_COUNT_W  = 17;
    localparam int HASH_COUNT_W = 4;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 17;

    localparam logic [CFG_INDEX_W-1:0] REG_BIT_COUNT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HASH_COUNT = 2'd1;

    localparam logic [BIT_COUNT_W-1:0]  BIT_COUNT_RST  = 17'h10000;
    localparam logic [HASH_COUNT_W-1:0] HASH_COUNT_RST = 4'd7;

    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic absorb;
        logic finish;
        logic clear;
    } hc_cmd_t;

    typedef struct packed {
        logic        done;
        logic [63:0] value;
    } hc_stat_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

endpackage

// ===== rtl/core/bloom_filter_xxh64_top.sv =====
// Flow: an item that completes no 32-byte stripe only fills the stripe buffer; one that completes a
// stripe also updates every accumulator (one accumulator update per lane and seed). A last item
// then runs, per probe, the hash finish steps on the multiplier and then the remainder unit.
// One item at a time; the result register frees input.
// Reset: synchronous, active low; then a clearing pass over all FILTER_BITS addresses zeroes the
// filter memory, during which s_ready stays low.
module bloom_filter_xxh64_top import bfx_pkg::*; #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_HASHES  = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_action,
    input  logic [63:0]             s_key_bytes,
    input  logic [3:0]              s_byte_count,
    input  logic                    s_key_last,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic                    m_done_action,
    output logic                    m_may_contain,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int ADDR_W = $clog2(FILTER_BITS);
    localparam int MOD_W  = $clog2(FILTER_BITS + 1);
    localparam int CNT_W  = $clog2(MAX_HASHES + 1);
    localparam int SEED_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;

    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T_ABS  = 3'd1;
    localparam logic [2:0] T_HASH = 3'd2;
    localparam logic [2:0] T_MOD  = 3'd3;
    localparam logic [2:0] T_RD   = 3'd4;
    localparam logic [2:0] T_EMIT = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic                    act_reg, act_next;
    logic                    last_reg, last_next;
    logic [BIT_COUNT_W-1:0]  bit_count_reg;
    logic [HASH_COUNT_W-1:0] hash_count_reg;
    logic [MOD_W-1:0]        modulus_reg, modulus_next;
    logic [CNT_W-1:0]        probes_reg, probes_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic                    all_set_reg, all_set_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_act_reg, m_act_next;
    logic                    m_hit_reg, m_hit_next;
    logic                    clr_active_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;

    logic                    filter_mem [FILTER_BITS];
    logic                    mem_rdata_reg;
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ADDR_W-1:0]       pos;

    hc_cmd_t                 hc_cmd;
    hc_stat_t                hc_stat;
    logic                    div_start;
    logic                    div_done;
    logic [MOD_W-1:0]        div_rem;

    logic [31:0]             bc32, hc32;
    logic [MOD_W-1:0]        modulus_sat;
    logic [CNT_W-1:0]        probes_sat;
    logic                    s_fire;
    logic                    out_free;

    bfx_hash #(
        .MAX_HASHES (MAX_HASHES)
    ) u_hash (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (hc_cmd),
        .seed       (idx_next[SEED_W-1:0]),
        .data       (s_key_bytes),
        .byte_count (s_byte_count),
        .stat       (hc_stat)
    );

    bfx_divmod #(
        .DIV_W (MOD_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (hc_stat.value),
        .divisor   (modulus_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    assign bc32 = 32'(bit_count_reg);
    assign hc32 = 32'(hash_count_reg);

    always_comb begin
        if (bc32 == 32'd0) begin
            modulus_sat = MOD_W'(1);
        end else if (bc32 > 32'(FILTER_BITS)) begin
            modulus_sat = MOD_W'(FILTER_BITS);
        end else begin
            modulus_sat = MOD_W'(bc32);
        end
        if (hc32 > 32'(MAX_HASHES)) begin
            probes_sat = CNT_W'(MAX_HASHES);
        end else begin
            probes_sat = CNT_W'(hc32);
        end
    end

    assign pos      = div_rem[ADDR_W-1:0];
    assign s_ready  = (state_reg == T_IDLE) && !clr_active_reg;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        last_next     = last_reg;
        modulus_next  = modulus_reg;
        probes_next   = probes_reg;
        idx_next      = idx_reg;
        all_set_next  = all_set_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_act_next    = m_act_reg;
        m_hit_next    = m_hit_reg;
        hc_cmd.absorb = 1'b0;
        hc_cmd.finish = 1'b0;
        hc_cmd.clear  = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            T_IDLE: begin
                if (s_fire) begin
                    act_next      = s_action;
                    last_next     = s_key_last;
                    hc_cmd.absorb = 1'b1;
                    state_next    = T_ABS;
                end
            end
            T_ABS: begin
                if (hc_stat.done) begin
                    if (!last_reg) begin
                        state_next = T_IDLE;
                    end else begin
                        modulus_next = modulus_sat;
                        probes_next  = probes_sat;
                        all_set_next = 1'b1;
                        idx_next     = '0;
                        if (probes_sat == '0) begin
                            state_next = T_EMIT;
                        end else begin
                            hc_cmd.finish = 1'b1;
                            state_next    = T_HASH;
                        end
                    end
                end
            end
            T_HASH: begin
                if (hc_stat.done) begin
                    div_start  = 1'b1;
                    state_next = T_MOD;
                end
            end
            T_MOD: begin
                if (div_done) begin
                    if (act_reg == ACT_QUERY) begin
                        state_next = T_RD;
                    end else begin
                        idx_next = idx_reg + CNT_W'(1);
                        if (idx_next == probes_reg) begin
                            state_next = T_EMIT;
                        end else begin
                            hc_cmd.finish = 1'b1;
                            state_next    = T_HASH;
                        end
                    end
                end
            end
            T_RD: begin
                if (!mem_rdata_reg) begin
                    all_set_next = 1'b0;
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_next == probes_reg) begin
                    state_next = T_EMIT;
                end else begin
                    hc_cmd.finish = 1'b1;
                    state_next    = T_HASH;
                end
            end
            T_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_act_next   = act_reg;
                    m_hit_next   = (act_reg == ACT_QUERY) && all_set_reg;
                    hc_cmd.clear = 1'b1;
                    state_next   = T_IDLE;
                end
            end
            default: begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign mem_we    = clr_active_reg
                       || (state_reg == T_MOD && div_done && act_reg == ACT_ADD);
    assign mem_waddr = clr_active_reg ? clr_addr_reg : pos;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            filter_mem[mem_waddr] <= !clr_active_reg;
        end
        mem_rdata_reg <= filter_mem[pos];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_IDLE;
            bit_count_reg  <= BIT_COUNT_RST;
            hash_count_reg <= HASH_COUNT_RST;
            m_valid_reg    <= 1'b0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    REG_BIT_COUNT:  bit_count_reg  <= cfg_wdata;
                    REG_HASH_COUNT: hash_count_reg <= cfg_wdata[HASH_COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(FILTER_BITS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
        end
        act_reg     <= act_next;
        last_reg    <= last_next;
        modulus_reg <= modulus_next;
        probes_reg  <= probes_next;
        idx_reg     <= idx_next;
        all_set_reg <= all_set_next;
        m_act_reg   <= m_act_next;
        m_hit_reg   <= m_hit_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_done_action = m_act_reg;
    assign m_may_contain = m_hit_reg;

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_fire && clr_active_reg))
        else $error("transaction accepted during filter clearing");

    a_accept_starts_absorb: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> state_reg == T_ABS)
        else $error("accepted transaction not absorbed");

    a_emit_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_EMIT && m_valid_reg && !m_ready) |=> state_reg == T_EMIT)
        else $error("result overwrote a pending transaction");

    a_add_never_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_act_reg == ACT_ADD && m_hit_reg))
        else $error("add reported may_contain");

endmodule

// ===== rtl/core/bfx_mul64.sv =====
module bfx_mul64 import bfx_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    logic [63:0] a_reg, a_next;
    logic [63:0] b_reg, b_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] mx, my;
    logic [63:0] mprod;

    always_comb begin
        case (step_reg)
            2'd0: begin
                mx = a_reg[31:0];
                my = b_reg[31:0];
            end
            2'd1: begin
                mx = a_reg[31:0];
                my = b_reg[63:32];
            end
            default: begin
                mx = a_reg[63:32];
                my = b_reg[31:0];
            end
        endcase
    end

    assign mprod = 64'(mx) * 64'(my);

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            if (step_reg == 2'd0) begin
                acc_next = mprod;
            end else begin
                acc_next[63:32] = acc_reg[63:32] + mprod[31:0];
            end
            if (step_reg == 2'd2) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            step_next = step_reg + 2'd1;
        end else if (start) begin
            a_next    = a;
            b_next    = b;
            step_next = 2'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== rtl/core/bfx_divmod.sv =====
module bfx_divmod import bfx_pkg::*; #(
    parameter int DIV_W = 17
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [63:0]      dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] remainder
);

    logic [63:0]      q_reg, q_next;
    logic [DIV_W-1:0] d_reg, d_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DIV_W:0]   trial;

    assign trial = {rem_reg, q_reg[63]};

    always_comb begin
        q_next    = q_reg;
        d_next    = d_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg) begin
            q_next = {q_reg[62:0], 1'b0};
            if (trial >= {1'b0, d_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, d_reg});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (start) begin
            q_next    = dividend;
            d_next    = divisor;
            rem_next  = '0;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg   <= q_next;
        d_reg   <= d_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/bfx_hash.sv =====
module bfx_hash import bfx_pkg::*; #(
    parameter int MAX_HASHES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  hc_cmd_t             cmd,
    input  logic [((MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1)-1:0] seed,
    input  logic [63:0]         data,
    input  logic [3:0]          byte_count,
    output hc_stat_t            stat
);

    localparam int SEED_W = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int ACC_AW = SEED_W + 2;
    localparam int ACC_DEPTH = MAX_HASHES * 4;
    localparam logic [ACC_AW-1:0] ENT_LAST = ACC_AW'(ACC_DEPTH - 1);

    localparam logic [4:0] H_IDLE    = 5'd0;
    localparam logic [4:0] H_ST_RD   = 5'd1;
    localparam logic [4:0] H_ST_M1   = 5'd2;
    localparam logic [4:0] H_ST_W1   = 5'd3;
    localparam logic [4:0] H_ST_W2   = 5'd4;
    localparam logic [4:0] H_SUM_RD  = 5'd5;
    localparam logic [4:0] H_SUM_ACC = 5'd6;
    localparam logic [4:0] H_MRG_RD  = 5'd7;
    localparam logic [4:0] H_MRG_M1  = 5'd8;
    localparam logic [4:0] H_MRG_M2  = 5'd9;
    localparam logic [4:0] H_MRG_M3  = 5'd10;
    localparam logic [4:0] H_MRG_M4  = 5'd11;
    localparam logic [4:0] H_LEN     = 5'd12;
    localparam logic [4:0] H_CHUNK   = 5'd13;
    localparam logic [4:0] H_C8_1    = 5'd14;
    localparam logic [4:0] H_C8_2    = 5'd15;
    localparam logic [4:0] H_C8_3    = 5'd16;
    localparam logic [4:0] H_C4_1    = 5'd17;
    localparam logic [4:0] H_C4_2    = 5'd18;
    localparam logic [4:0] H_C1_1    = 5'd19;
    localparam logic [4:0] H_C1_2    = 5'd20;
    localparam logic [4:0] H_AV_1    = 5'd21;
    localparam logic [4:0] H_AV_2    = 5'd22;

    logic [4:0]        state_reg, state_next;
    logic [5:0]        fill_reg, fill_next;
    logic [63:0]       len_reg, len_next;
    logic              seen_reg, seen_next;
    logic              done_reg, done_next;
    logic [319:0]      sbuf_reg, sbuf_next;
    logic [63:0]       h_reg, h_next;
    logic [63:0]       t_reg, t_next;
    logic [5:0]        pos_reg, pos_next;
    logic [1:0]        lane_reg, lane_next;
    logic [ACC_AW-1:0] ent_reg, ent_next;
    logic [SEED_W-1:0] seed_reg, seed_next;

    logic [63:0]       acc_mem [ACC_DEPTH];
    logic [63:0]       acc_rdata_reg;
    logic [ACC_AW-1:0] acc_raddr;
    logic              acc_we;

    logic              mul_start;
    logic [63:0]       mul_a, mul_b, mul_p;
    logic              mul_done;

    logic [1:0]        word_idx;
    logic [63:0]       rword;
    logic [63:0]       seed_val;
    logic [63:0]       sum_term;
    logic [3:0]        cnt_sat;
    logic [5:0]        fill_sum;

    bfx_mul64 u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign word_idx = (state_reg == H_ST_M1) ? ent_reg[1:0] : pos_reg[4:3];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            rword[8*k +: 8] = sbuf_reg[64*word_idx + 8*k +: 8];
        end
    end

    always_comb begin
        case (ent_reg[1:0])
            2'd0:    seed_val = 64'(ent_reg[ACC_AW-1:2]) + PR1 + PR2;
            2'd1:    seed_val = 64'(ent_reg[ACC_AW-1:2]) + PR2;
            2'd2:    seed_val = 64'(ent_reg[ACC_AW-1:2]);
            default: seed_val = 64'(ent_reg[ACC_AW-1:2]) - PR1;
        endcase
    end

    always_comb begin
        case (lane_reg)
            2'd0:    sum_term = rotl64(acc_rdata_reg, 1);
            2'd1:    sum_term = rotl64(acc_rdata_reg, 7);
            2'd2:    sum_term = rotl64(acc_rdata_reg, 12);
            default: sum_term = rotl64(acc_rdata_reg, 18);
        endcase
    end

    assign cnt_sat  = (byte_count > 4'd8) ? 4'd8 : byte_count;
    assign fill_sum = fill_reg + {2'b00, cnt_sat};

    assign acc_raddr = (state_reg == H_ST_RD) ? ent_reg : {seed_reg, lane_reg};

    always_comb begin
        logic [5:0] off;
        state_next = state_reg;
        fill_next  = fill_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        done_next  = 1'b0;
        sbuf_next  = sbuf_reg;
        h_next     = h_reg;
        t_next     = t_reg;
        pos_next   = pos_reg;
        lane_next  = lane_reg;
        ent_next   = ent_reg;
        seed_next  = seed_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        acc_we     = 1'b0;
        off        = '0;
        case (state_reg)
            H_IDLE: begin
                if (cmd.clear) begin
                    fill_next = '0;
                    len_next  = '0;
                    seen_next = 1'b0;
                end else if (cmd.absorb) begin
                    for (int j = 0; j < 40; j++) begin
                        off = 6'(j) - fill_reg;
                        if (6'(j) >= fill_reg && off < {2'b00, cnt_sat}) begin
                            sbuf_next[8*j +: 8] = data[8*off[2:0] +: 8];
                        end
                    end
                    fill_next = fill_sum;
                    len_next  = len_reg + 64'(cnt_sat);
                    ent_next  = '0;
                    if (fill_sum >= 6'd32) begin
                        state_next = H_ST_RD;
                    end else begin
                        done_next = 1'b1;
                    end
                end else if (cmd.finish) begin
                    seed_next = seed;
                    lane_next = 2'd0;
                    if (seen_reg) begin
                        h_next     = '0;
                        state_next = H_SUM_RD;
                    end else begin
                        h_next     = 64'(seed) + PR5;
                        state_next = H_LEN;
                    end
                end
            end
            H_ST_RD: begin
                state_next = H_ST_M1;
            end
            H_ST_M1: begin
                t_next     = seen_reg ? acc_rdata_reg : seed_val;
                mul_start  = 1'b1;
                mul_a      = rword;
                mul_b      = PR2;
                state_next = H_ST_W1;
            end
            H_ST_W1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = rotl64(t_reg + mul_p, 31);
                    mul_b      = PR1;
                    state_next = H_ST_W2;
                end
            end
            H_ST_W2: begin
                if (mul_done) begin
                    acc_we = 1'b1;
                    if (ent_reg == ENT_LAST) begin
                        sbuf_next[63:0] = sbuf_reg[319:256];
                        fill_next  = fill_reg - 6'd32;
                        seen_next  = 1'b1;
                        done_next  = 1'b1;
                        state_next = H_IDLE;
                    end else begin
                        ent_next   = ent_reg + ACC_AW'(1);
                        state_next = H_ST_RD;
                    end
                end
            end
            H_SUM_RD: begin
                state_next = H_SUM_ACC;
            end
            H_SUM_ACC: begin
                h_next = h_reg + sum_term;
                if (lane_reg == 2'd3) begin
                    lane_next  = 2'd0;
                    state_next = H_MRG_RD;
                end else begin
                    lane_next  = lane_reg + 2'd1;
                    state_next = H_SUM_RD;
                end
            end
            H_MRG_RD: begin
                state_next = H_MRG_M1;
            end
            H_MRG_M1: begin
                mul_start  = 1'b1;
                mul_a      = acc_rdata_reg;
                mul_b      = PR2;
                state_next = H_MRG_M2;
            end
            H_MRG_M2: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = rotl64(mul_p, 31);
                    mul_b      = PR1;
                    state_next = H_MRG_M3;
                end
            end
            H_MRG_M3: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = h_reg ^ mul_p;
                    mul_b      = PR1;
                    state_next = H_MRG_M4;
                end
            end
            H_MRG_M4: begin
                if (mul_done) begin
                    h_next = mul_p + PR4;
                    if (lane_reg == 2'd3) begin
                        state_next = H_LEN;
                    end else begin
                        lane_next  = lane_reg + 2'd1;
                        state_next = H_MRG_RD;
                    end
                end
            end
            H_LEN: begin
                h_next     = h_reg + len_reg;
                pos_next   = '0;
                state_next = H_CHUNK;
            end
            H_CHUNK: begin
                mul_start = 1'b1;
                if ({1'b0, pos_reg} + 7'd8 <= {1'b0, fill_reg}) begin
                    mul_a      = rword;
                    mul_b      = PR2;
                    state_next = H_C8_1;
                end else if ({1'b0, pos_reg} + 7'd4 <= {1'b0, fill_reg}) begin
                    mul_a      = pos_reg[2] ? {32'd0, rword[63:32]} : {32'd0, rword[31:0]};
                    mul_b      = PR1;
                    state_next = H_C4_1;
                end else if (pos_reg < fill_reg) begin
                    mul_a      = {56'd0, rword[8*pos_reg[2:0] +: 8]};
                    mul_b      = PR5;
                    state_next = H_C1_1;
                end else begin
                    mul_a      = h_reg ^ (h_reg >> 33);
                    mul_b      = PR2;
                    state_next = H_AV_1;
                end
            end
            H_C8_1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = rotl64(mul_p, 31);
                    mul_b      = PR1;
                    state_next = H_C8_2;
                end
            end
            H_C8_2: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = rotl64(h_reg ^ mul_p, 27);
                    mul_b      = PR1;
                    state_next = H_C8_3;
                end
            end
            H_C8_3: begin
                if (mul_done) begin
                    h_next     = mul_p + PR4;
                    pos_next   = pos_reg + 6'd8;
                    state_next = H_CHUNK;
                end
            end
            H_C4_1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = rotl64(h_reg ^ mul_p, 23);
                    mul_b      = PR2;
                    state_next = H_C4_2;
                end
            end
            H_C4_2: begin
                if (mul_done) begin
                    h_next     = mul_p + PR3;
                    pos_next   = pos_reg + 6'd4;
                    state_next = H_CHUNK;
                end
            end
            H_C1_1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = rotl64(h_reg ^ mul_p, 11);
                    mul_b      = PR1;
                    state_next = H_C1_2;
                end
            end
            H_C1_2: begin
                if (mul_done) begin
                    h_next     = mul_p;
                    pos_next   = pos_reg + 6'd1;
                    state_next = H_CHUNK;
                end
            end
            H_AV_1: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = mul_p ^ (mul_p >> 29);
                    mul_b      = PR3;
                    state_next = H_AV_2;
                end
            end
            H_AV_2: begin
                if (mul_done) begin
                    h_next     = mul_p ^ (mul_p >> 32);
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default: begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (acc_we) begin
            acc_mem[ent_reg] <= mul_p;
        end
        acc_rdata_reg <= acc_mem[acc_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= H_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            seen_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            done_reg  <= done_next;
        end
        sbuf_reg <= sbuf_next;
        h_reg    <= h_next;
        t_reg    <= t_next;
        pos_reg  <= pos_next;
        lane_reg <= lane_next;
        ent_reg  <= ent_next;
        seed_reg <= seed_next;
    end

    assign stat.done  = done_reg;
    assign stat.value = h_reg;

endmodule

// ===== verif/bloom_probe_checker.sv =====
module bloom_probe_checker import bfx_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic                   s_action,
    input  logic [63:0]            s_key_bytes,
    input  logic [3:0]             s_byte_count,
    input  logic                   s_key_last,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_done_action,
    input  logic                   m_may_contain,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     mismatches,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic act;
        logic hit;
    } verdict_t;

    verdict_t     verdicts[$];
    logic [63:0]  lanes[8][4];
    logic [63:0]  stripe[4];
    int           fill;
    logic [63:0]  key_len;
    bit           bitmap[65536];
    logic [16:0]  bits_reg;
    logic [3:0]   hashes_reg;

    function automatic logic [63:0] rol(logic [63:0] x, int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] round64(logic [63:0] acc, logic [63:0] din);
        acc = acc + din * PR2;
        acc = rol(acc, 31);
        return acc * PR1;
    endfunction

    function automatic logic [63:0] merge64(logic [63:0] acc, logic [63:0] v);
        acc = acc ^ round64(64'd0, v);
        return acc * PR1 + PR4;
    endfunction

    task automatic restart_key();
        for (int i = 0; i < 8; i++) begin
            lanes[i][0] = 64'(i) + PR1 + PR2;
            lanes[i][1] = 64'(i) + PR2;
            lanes[i][2] = 64'(i);
            lanes[i][3] = 64'(i) - PR1;
        end
        for (int j = 0; j < 4; j++) stripe[j] = '0;
        fill = 0;
        key_len = '0;
    endtask

    function automatic logic [7:0] stripe_byte(int p);
        return stripe[(p >> 3) & 3][(p & 7) * 8 +: 8];
    endfunction

    function automatic logic [63:0] stripe_word(int p, int n);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < n; k++) v[k * 8 +: 8] = stripe_byte(p + k);
        return v;
    endfunction

    task automatic absorb_byte(logic [7:0] b);
        stripe[fill >> 3][(fill & 7) * 8 +: 8] = b;
        fill++;
        if (fill >= 32) begin
            for (int i = 0; i < 8; i++)
                for (int j = 0; j < 4; j++) lanes[i][j] = round64(lanes[i][j], stripe[j]);
            for (int j = 0; j < 4; j++) stripe[j] = '0;
            fill = 0;
        end
    endtask

    function automatic logic [63:0] digest(int seed);
        logic [63:0] h;
        int p;
        p = 0;
        if (key_len >= 32) begin
            h = rol(lanes[seed][0], 1) + rol(lanes[seed][1], 7) + rol(lanes[seed][2], 12)
                + rol(lanes[seed][3], 18);
            for (int j = 0; j < 4; j++) h = merge64(h, lanes[seed][j]);
        end else begin
            h = 64'(seed) + PR5;
        end
        h = h + key_len;
        while (p + 8 <= fill) begin
            h = h ^ round64(64'd0, stripe_word(p, 8));
            h = rol(h, 27) * PR1 + PR4;
            p += 8;
        end
        if (p + 4 <= fill) begin
            h = h ^ (stripe_word(p, 4) * PR1);
            h = rol(h, 23) * PR2 + PR3;
            p += 4;
        end
        while (p < fill) begin
            h = h ^ (64'(stripe_byte(p)) * PR5);
            h = rol(h, 11) * PR1;
            p++;
        end
        h = h ^ (h >> 33);
        h = h * PR2;
        h = h ^ (h >> 29);
        h = h * PR3;
        h = h ^ (h >> 32);
        return h;
    endfunction

    task automatic absorb_transaction(logic act, logic [63:0] data, logic [3:0] cnt,
                                      logic last);
        int n;
        logic [63:0] modulus;
        int probes;
        logic [63:0] pos;
        logic all_set;
        n = (cnt > 8) ? 8 : int'(cnt);
        for (int k = 0; k < n; k++) absorb_byte(data[k * 8 +: 8]);
        key_len = key_len + 64'(n);
        if (last) begin
            modulus = (bits_reg == 0) ? 64'd1 : (bits_reg > 65536) ? 64'd65536 : 64'(bits_reg);
            probes = (hashes_reg > 8) ? 8 : int'(hashes_reg);
            all_set = 1'b1;
            for (int i = 0; i < probes; i++) begin
                pos = digest(i) % modulus;
                if (act == ACT_ADD) bitmap[pos[15:0]] = 1'b1;
                else if (!bitmap[pos[15:0]]) all_set = 1'b0;
            end
            verdicts.push_back('{act: act, hit: (act == ACT_QUERY) && all_set});
            restart_key();
        end
    endtask

    task automatic report(string what, logic got, logic want);
        $display("%0t mismatch on %s: got %0b, expected %0b", $realtime, what, got, want);
        mismatches++;
    endtask

    initial begin
        mismatches = 0;
        outstanding = 0;
        bits_reg = BIT_COUNT_RST;
        hashes_reg = HASH_COUNT_RST;
        foreach (bitmap[i]) bitmap[i] = 1'b0;
        restart_key();
    end

    always @(posedge aclk) begin
        verdict_t v;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (verdicts.size() == 0) begin
                    $display("%0t unexpected result transaction", $realtime);
                    mismatches++;
                end else begin
                    v = verdicts.pop_front();
                    if (m_done_action !== v.act) report("done_action", m_done_action, v.act);
                    if (m_may_contain !== v.hit) report("may_contain", m_may_contain, v.hit);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_BIT_COUNT:  bits_reg = cfg_wdata[BIT_COUNT_W-1:0];
                    REG_HASH_COUNT: hashes_reg = cfg_wdata[HASH_COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                absorb_transaction(s_action, s_key_bytes, s_byte_count, s_key_last);
            outstanding = verdicts.size();
        end
    end
endmodule

// ===== verif/tb_bloom_filter_xxh64_top.sv =====
module tb_bloom_filter_xxh64_top;
    import bfx_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int RANDOM_ITEMS = 850;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic                   s_action = 1'b0;
    logic [63:0]            s_key_bytes = '0;
    logic [3:0]             s_byte_count = '0;
    logic                   s_key_last = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_done_action;
    logic                   m_may_contain;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    int                     mismatches;
    int                     outstanding;
    int                     cycles = 0;
    int                     sent = 0;
    int                     stall_left = 0;

    logic [63:0] kept_data[64][12];
    logic [3:0]  kept_cnt[64][12];
    int          kept_len[64];
    int          kept_num = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    bloom_filter_xxh64_top DUT (.*);

    bloom_probe_checker u_checker (.*);

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_bloom_filter_xxh64_top failed");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            m_ready <= (stall_left == 0);
        end
    end

    task automatic send(logic act, logic [63:0] data, logic [3:0] cnt, logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_key_bytes <= data;
        s_byte_count <= cnt;
        s_key_last <= last;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic settle();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(posedge aclk);
        repeat (2000) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic setup(logic [CFG_DATA_W-1:0] bits, logic [CFG_DATA_W-1:0] hashes);
        settle();
        write_reg(REG_BIT_COUNT, bits);
        write_reg(REG_HASH_COUNT, hashes);
    endtask

    // fresh key: well formed unless broken is set; kept for later replay
    task automatic fresh_key(logic act, bit broken);
        int n;
        int slot;
        logic [63:0] d;
        logic [3:0] c;
        n = ($urandom_range(0, 6) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        slot = (kept_num < 64) ? kept_num : $urandom_range(0, 63);
        if (kept_num < 64) kept_num++;
        kept_len[slot] = n;
        for (int i = 0; i < n; i++) begin
            d = {$urandom, $urandom};
            if (broken) c = 4'($urandom_range(0, 15));
            else if (i == n - 1) c = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                                  : 4'($urandom_range(0, 8));
            else c = 4'd8;
            kept_data[slot][i] = d;
            kept_cnt[slot][i] = c;
            send(act, d, c, i == n - 1);
        end
    endtask

    task automatic replay_key(logic act);
        int slot;
        slot = $urandom_range(0, kept_num - 1);
        for (int i = 0; i < kept_len[slot]; i++)
            send(act, kept_data[slot][i], kept_cnt[slot][i], i == kept_len[slot] - 1);
    endtask

    initial begin
        int r;
        int next_cfg;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send(ACT_ADD, '0, 4'd0, 1'b1);
        send(ACT_QUERY, '0, 4'd0, 1'b1);
        send(ACT_QUERY, '1, 4'd8, 1'b1);
        send(ACT_ADD, '1, 4'd8, 1'b1);
        send(ACT_QUERY, '1, 4'd8, 1'b1);
        send(ACT_ADD, '1, 4'd15, 1'b1);
        for (int i = 0; i < 5; i++) send(ACT_ADD, {32'hA5A5_5A5A, 32'(i)}, 4'd8, i == 4);
        for (int i = 0; i < 5; i++) send(ACT_QUERY, {32'hA5A5_5A5A, 32'(i)}, 4'd8, i == 4);
        send(ACT_ADD, 64'h0123_4567_89AB_CDEF, 4'd3, 1'b0);
        send(ACT_ADD, 64'hFEDC_BA98_7654_3210, 4'd8, 1'b1);
        setup(17'd1, 17'd0);
        send(ACT_ADD, 64'h55, 4'd1, 1'b1);
        send(ACT_QUERY, 64'h77, 4'd1, 1'b1);
        setup(17'd0, 17'd15);
        send(ACT_QUERY, 64'h99, 4'd4, 1'b1);
        setup(17'h1FFFF, 17'd8);
        write_reg(2'd2, 17'd5);
        write_reg(2'd3, 17'd0);
        send(ACT_ADD, 64'hDEAD_BEEF, 4'd4, 1'b1);
        send(ACT_QUERY, 64'hDEAD_BEEF, 4'd4, 1'b1);

        setup(17'd65536, 17'd7);
        sent = 0;
        next_cfg = 120;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_cfg) begin
                next_cfg += 120;
                case ($urandom_range(0, 5))
                    0: setup(17'd1, 17'd1);
                    1: setup(17'd65536, 17'd8);
                    2: setup(17'h1FFFF, 17'd15);
                    3: setup(17'd0, 17'd0);
                    4: setup(17'($urandom_range(2, 4000)), 17'($urandom_range(1, 8)));
                    default: setup(17'($urandom), 17'($urandom_range(0, 15)));
                endcase
                if ($urandom_range(0, 1)) write_reg(2'($urandom_range(2, 3)), 17'($urandom));
            end
            r = $urandom_range(0, 99);
            if (r < 50 || kept_num == 0) fresh_key(r < 35 ? ACT_ADD : ACT_QUERY, 1'b0);
            else if (r < 88) replay_key(1'($urandom_range(0, 2) != 0));
            else fresh_key(1'($urandom), 1'b1);
        end

        settle();
        if (mismatches == 0) begin
            $display("tb_bloom_filter_xxh64_top passed");
        end else begin
            $display("tb_bloom_filter_xxh64_top failed");
        end
        $finish;
    end
endmodule

// ===== bloom_filter_xxh64_top.f =====
rtl/core/bfx_pkg.sv
rtl/core/bfx_mul64.sv
rtl/core/bfx_divmod.sv
rtl/core/bfx_hash.sv
rtl/core/bloom_filter_xxh64_top.sv
verif/bloom_probe_checker.sv
verif/tb_bloom_filter_xxh64_top.sv
